// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the compensation RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("compensation check failed");
`define TPC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("compensation check failed");
`else
`define TPC_ASSERT(label, clk, rst_n, prop)
`define TPC_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// ===== hdl/tpc_pkg.sv =====
// Types and constants for the temperature and pressure compensation block.
// No dependencies; used by tpc_div and temp_pressure_compensation.
package tpc_pkg;

    localparam int DIV_W = 32;

    typedef enum logic [1:0] {
        CFG_TEMP_CALIB    = 2'd0,
        CFG_PRESS_CALIB_A = 2'd1,
        CFG_PRESS_CALIB_B = 2'd2,
        CFG_PRESS_CALIB_C = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               post_shift;
        logic               fault;
        logic signed [26:0] temp;
        logic signed [31:0] fine;
    } t_side;

endpackage

// ===== hdl/tpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on tpc_pkg for its default width and on assert_macros.svh.
`include "assert_macros.svh"
module tpc_div #(
    parameter int WIDTH  = tpc_pkg::DIV_W,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [WIDTH-1:0]  i_dividend,
    input  logic [WIDTH-1:0]  i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_quotient,
    output logic [SIDE_W-1:0] o_side
);

    logic [WIDTH-1:0]  r_rem  [0:WIDTH];
    logic [WIDTH-1:0]  r_quo  [0:WIDTH];
    logic [WIDTH-1:0]  r_dsr  [0:WIDTH];
    logic [SIDE_W-1:0] r_side [0:WIDTH];
    logic [WIDTH:0]    r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_quo[0]  <= i_dividend;
            r_dsr[0]  <= i_divisor;
            r_side[0] <= i_side;
        end
    end

    for (genvar gi = 1; gi <= WIDTH; gi++) begin : g_stage
        logic [WIDTH:0]   w_sh;
        logic [WIDTH:0]   w_diff;
        logic             w_ge;

        assign w_sh   = {r_rem[gi-1], r_quo[gi-1][WIDTH-1]};
        assign w_diff = w_sh - {1'b0, r_dsr[gi-1]};
        assign w_ge   = !w_diff[WIDTH];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi] <= 1'b0;
            end else if (i_en) begin
                r_v[gi] <= r_v[gi-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi]  <= w_ge ? w_diff[WIDTH-1:0] : w_sh[WIDTH-1:0];
                r_quo[gi]  <= {r_quo[gi-1][WIDTH-2:0], w_ge};
                r_dsr[gi]  <= r_dsr[gi-1];
                r_side[gi] <= r_side[gi-1];
            end
        end
    end

    assign o_valid    = r_v[WIDTH];
    assign o_quotient = r_quo[WIDTH];
    assign o_side     = r_side[WIDTH];

    `TPC_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, !i_en, $stable(r_v))
    `TPC_ASSERT_NEXT(a_div_side_hold, i_clk, i_rst_n, !i_en, $stable(o_side))
    `TPC_ASSERT_NEXT(a_div_step, i_clk, i_rst_n, i_en && r_v[0], r_v[1])

endmodule

// ===== hdl/temp_pressure_compensation.sv =====
// Top level of the integer temperature and pressure compensation pipeline.
// Depends on tpc_pkg, tpc_div and assert_macros.svh.
//
// Channel    Direction  Handshake                   Payload
// input      in         i_valid / o_ready           i_temp_raw, i_pressure_raw
// result     out        o_valid / i_ready           o_temperature_centi, o_fine_temperature,
//                                                   o_pressure_pa, o_divide_fault
// config     in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request enters per cycle while o_ready is high.
// The divider has 33 stages: an input register, then one quotient bit per stage.
// Reset clears the calibration registers and every stage valid bit.
// A stall on the result side freezes the whole pipeline and o_ready drops.
`include "assert_macros.svh"
module temp_pressure_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_temp_raw,
    input  logic [19:0]        i_pressure_raw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [26:0] o_temperature_centi,
    output logic signed [31:0] o_fine_temperature,
    output logic [31:0]        o_pressure_pa,
    output logic               o_divide_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);

    localparam int SIDE_W = $bits(tpc_pkg::t_side);

    logic [39:0] r_temp_calib;
    logic [39:0] r_press_calib_a;
    logic [39:0] r_press_calib_b_lo;
    logic [7:0]  r_press_calib_b_hi;
    logic [39:0] r_press_calib_c;

    logic w_adv;
    assign w_adv       = !o_valid || i_ready;
    assign o_ready     = w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib       <= '0;
            r_press_calib_a    <= '0;
            r_press_calib_b_lo <= '0;
            r_press_calib_b_hi <= '0;
            r_press_calib_c    <= '0;
        end else if (i_cfg_valid) begin
            case (tpc_pkg::t_cfg_idx'(i_cfg_index))
                tpc_pkg::CFG_TEMP_CALIB:    r_temp_calib    <= i_cfg_data[39:0];
                tpc_pkg::CFG_PRESS_CALIB_A: r_press_calib_a <= i_cfg_data[39:0];
                tpc_pkg::CFG_PRESS_CALIB_B: begin
                    r_press_calib_b_lo <= i_cfg_data[39:0];
                    r_press_calib_b_hi <= i_cfg_data[47:40];
                end
                tpc_pkg::CFG_PRESS_CALIB_C: r_press_calib_c <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2;
    logic signed [7:0]  w_t3;
    logic [31:0]        w_p1;
    logic signed [31:0] w_p2, w_p3s, w_p4s, w_p5, w_p6, w_p7s, w_p8, w_p9, w_p10;

    assign w_t1  = r_temp_calib[15:0];
    assign w_t2  = r_temp_calib[31:16];
    assign w_t3  = r_temp_calib[39:32];
    assign w_p1  = {16'b0, r_press_calib_a[15:0]};
    assign w_p2  = 32'($signed(r_press_calib_a[31:16]));
    assign w_p3s = 32'($signed(r_press_calib_a[39:32])) <<< 5;
    assign w_p4s = {r_press_calib_b_lo[15:0], 16'b0};
    assign w_p5  = 32'($signed(r_press_calib_b_lo[31:16]));
    assign w_p6  = 32'($signed(r_press_calib_b_lo[39:32]));
    assign w_p7s = 32'($signed(r_press_calib_b_hi)) <<< 7;
    assign w_p8  = 32'($signed(r_press_calib_c[15:0]));
    assign w_p9  = 32'($signed(r_press_calib_c[31:16]));
    assign w_p10 = {24'b0, r_press_calib_c[39:32]};

    logic [9:1] r_pre_v;
    logic [5:1] r_post_v;

    // Temperature polynomial.
    logic signed [17:0] w_a;
    logic signed [16:0] w_h;
    assign w_a = $signed({1'b0, i_temp_raw[19:3]}) - $signed({1'b0, w_t1, 1'b0});
    assign w_h = w_a[17:1];

    logic signed [33:0] r1_ab, r1_hh;
    logic [19:0]        r1_praw;
    logic signed [22:0] r2_b;
    logic signed [33:0] r2_cm;
    logic [19:0]        r2_praw;
    logic signed [31:0] r3_fine;
    logic [19:0]        r3_praw;
    logic signed [31:0] r4_v1, r4_fine;
    logic signed [26:0] r4_temp;
    logic [19:0]        r4_praw;
    logic signed [31:0] r5_qq, r5_m2, r5_m3, r5_fine;
    logic signed [26:0] r5_temp;
    logic [19:0]        r5_praw;
    logic signed [31:0] r6_a, r6_b, r6_m2, r6_m3, r6_fine;
    logic signed [26:0] r6_temp;
    logic [19:0]        r6_praw;
    logic signed [31:0] r7_v2, r7_v1s, r7_fine;
    logic signed [26:0] r7_temp;
    logic [19:0]        r7_praw;
    logic signed [31:0] r8_m, r8_fine;
    logic [31:0]        r8_pc0;
    logic signed [26:0] r8_temp;
    logic signed [31:0] r9_div, r9_fine;
    logic [31:0]        r9_pc;
    logic signed [26:0] r9_temp;

    logic signed [35:0] w_f5;
    logic signed [31:0] w_q, w_t7, w_v2, w_v1b;
    assign w_f5  = 36'(r3_fine) + (36'(r3_fine) <<< 2) + 36'sd128;
    assign w_q   = r4_v1 >>> 2;
    assign w_t7  = (r6_a >>> 2) + (r6_m2 <<< 1);
    assign w_v2  = (w_t7 >>> 2) + w_p4s;
    assign w_v1b = ((r6_b >>> 3) + (r6_m3 >>> 1)) >>> 18;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_v <= '0;
        end else if (w_adv) begin
            r_pre_v <= {r_pre_v[8:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ab   <= 34'(w_a) * 34'(w_t2);
            r1_hh   <= 34'(w_h) * 34'(w_h);
            r1_praw <= i_pressure_raw;

            r2_b    <= r1_ab[33:11];
            r2_cm   <= 34'($signed(r1_hh[33:12])) * 34'($signed({w_t3, 4'b0}));
            r2_praw <= r1_praw;

            r3_fine <= 32'(r2_b) + 32'($signed(r2_cm[33:14]));
            r3_praw <= r2_praw;

            r4_v1   <= (r3_fine >>> 1) - 32'sd64000;
            r4_temp <= w_f5[34:8];
            r4_fine <= r3_fine;
            r4_praw <= r3_praw;

            r5_qq   <= w_q * w_q;
            r5_m2   <= r4_v1 * w_p5;
            r5_m3   <= w_p2 * r4_v1;
            r5_fine <= r4_fine;
            r5_temp <= r4_temp;
            r5_praw <= r4_praw;

            r6_a    <= (r5_qq >>> 11) * w_p6;
            r6_b    <= (r5_qq >>> 13) * w_p3s;
            r6_m2   <= r5_m2;
            r6_m3   <= r5_m3;
            r6_fine <= r5_fine;
            r6_temp <= r5_temp;
            r6_praw <= r5_praw;

            r7_v2   <= w_v2;
            r7_v1s  <= 32'sd32768 + w_v1b;
            r7_fine <= r6_fine;
            r7_temp <= r6_temp;
            r7_praw <= r6_praw;

            r8_m    <= r7_v1s * $signed(w_p1);
            r8_pc0  <= 32'd1048576 - {12'b0, r7_praw} - 32'(r7_v2 >>> 12);
            r8_fine <= r7_fine;
            r8_temp <= r7_temp;

            r9_div  <= r8_m >>> 15;
            r9_pc   <= r8_pc0 * 32'd3125;
            r9_fine <= r8_fine;
            r9_temp <= r8_temp;
        end
    end

    // Division stage.
    tpc_pkg::t_side w_side_in, w_side_out;
    logic           w_big;
    logic [31:0]    w_dvd;
    logic [31:0]    w_quo;
    logic           w_div_v;

    assign w_big = r9_pc[31:30] != 2'b00;
    assign w_dvd = w_big ? r9_pc : {r9_pc[30:0], 1'b0};
    assign w_side_in = '{post_shift: w_big, fault: (r9_div == 32'sd0),
                         temp: r9_temp, fine: r9_fine};

    tpc_div #(
        .WIDTH  (tpc_pkg::DIV_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_pre_v[9]),
        .i_dividend (w_dvd),
        .i_divisor  (r9_div),
        .i_side     (w_side_in),
        .o_valid    (w_div_v),
        .o_quotient (w_quo),
        .o_side     (w_side_out)
    );

    // Correction polynomial after the division.
    tpc_pkg::t_side     r11_s, r12_s, r13_s, r14_s, r15_s;
    logic [31:0]        r11_pc, r12_pc, r13_pc, r14_pc, r15_pc;
    logic [31:0]        r12_ee, r12_cb2, r13_cb3;
    logic signed [31:0] r12_x2m, r13_x2m, r13_x1m;
    logic signed [31:0] r14_x1, r14_x2, r14_x3m, r15_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_post_v <= '0;
            o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_post_v <= {r_post_v[4:1], w_div_v};
            o_valid  <= r_post_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_pc  <= w_side_out.post_shift ? {w_quo[30:0], 1'b0} : w_quo;
            r11_s   <= w_side_out;

            r12_ee  <= {3'b0, r11_pc[31:3]} * {3'b0, r11_pc[31:3]};
            r12_x2m <= $signed({2'b0, r11_pc[31:2]}) * w_p8;
            r12_cb2 <= {8'b0, r11_pc[31:8]} * {8'b0, r11_pc[31:8]};
            r12_pc  <= r11_pc;
            r12_s   <= r11_s;

            r13_x1m <= w_p9 * $signed({13'b0, r12_ee[31:13]});
            r13_cb3 <= r12_cb2 * {8'b0, r12_pc[31:8]};
            r13_x2m <= r12_x2m;
            r13_pc  <= r12_pc;
            r13_s   <= r12_s;

            r14_x1  <= r13_x1m >>> 12;
            r14_x2  <= r13_x2m >>> 13;
            r14_x3m <= $signed(r13_cb3) * w_p10;
            r14_pc  <= r13_pc;
            r14_s   <= r13_s;

            r15_sum <= r14_x1 + r14_x2 + (r14_x3m >>> 17) + w_p7s;
            r15_pc  <= r14_pc;
            r15_s   <= r14_s;

            o_pressure_pa       <= r15_s.fault ? 32'd0 : r15_pc + 32'(r15_sum >>> 4);
            o_divide_fault      <= r15_s.fault;
            o_temperature_centi <= r15_s.temp;
            o_fine_temperature  <= r15_s.fine;
        end
    end

    `TPC_ASSERT(a_fault_zero, i_clk, i_rst_n, o_valid && o_divide_fault |-> o_pressure_pa == 32'd0)
    `TPC_ASSERT_NEXT(a_pre_hold, i_clk, i_rst_n, !w_adv, $stable(r_pre_v) && $stable(r9_pc))
    `TPC_ASSERT_NEXT(a_post_hold, i_clk, i_rst_n, !w_adv, $stable(r_post_v) && $stable(r15_sum))
    `TPC_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, w_adv && r_post_v[5], o_valid)

endmodule
